FILE: rtl/core/command_text_tokenizer_unit_defines.svh
// Assertion macros for the command text tokenizer.
// No dependencies; included by the top level before its module header.
`ifndef COMMAND_TEXT_TOKENIZER_UNIT_DEFINES_SVH
`define COMMAND_TEXT_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CTT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ctt_pkg.sv
// Types, character codes and classifier functions for the command text tokenizer.
// No dependencies.
package ctt_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] kind;
        logic       last_in_run;
    } t_out_item;

    localparam logic [1:0] KIND_CHAR      = 2'd0;
    localparam logic [1:0] KIND_END_TOKEN = 2'd1;
    localparam logic [1:0] KIND_END_CMDS  = 2'd2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EOC    = 8'hFF;

    // most results one byte can cause
    localparam int MAX_RESULTS = 4;

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_NUL) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB)
            || (c == CH_SPACE) || (c == CH_COMMA);
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return (c == CH_DQUOTE) || (c == CH_SQUOTE);
    endfunction

endpackage

FILE: rtl/core/command_text_tokenizer_unit.sv
// Command text tokenizer top level: input register, per-byte decode, result register.
// Depends on ctt_pkg and command_text_tokenizer_unit_defines.svh.
//
// Usage:
//   Input channel (i_in_valid / i_in_data / o_in_stall) takes one text byte per beat,
//   with end_of_input marking the last byte of the stream. Output channel
//   (o_out_valid / o_out_data / i_out_stall) gives token characters, end-of-token
//   markers and one end-of-commands marker; last_in_run flags the final result of
//   each byte. i_cfg_wr_en / i_cfg_wr_data write comments_enabled while idle.
// Path: a byte taken into the input register is decoded; its results are registered.
// Throughput: one byte per cycle, while the output is not stalled, for bytes that
//   give at most one result. A byte with several results holds the input register
//   until its last result is taken, since the single result register takes one
//   result per cycle. Bytes with no result retire even while the output stalls.
// Reset: scan state returns to between tokens, comments_enabled to 1, both
//   channels empty. After end of commands every byte is consumed silently until
//   the next reset.
// Stall: a stalled result holds in the output register; a held byte that still
//   has results to give then stays in the input register and o_in_stall rises.
`include "command_text_tokenizer_unit_defines.svh"

module command_text_tokenizer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ctt_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output ctt_pkg::t_out_item o_out_data,
    input  logic               i_out_stall,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data
);
    import ctt_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_PLAIN   = 6'b000010,
        ST_QUOTE   = 6'b000100,
        ST_SLASH   = 6'b001000,
        ST_COMMENT = 6'b010000,
        ST_DONE    = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic       r_comments_en;
    logic       r_in_valid;
    t_in_item   r_in;
    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out_item  r_out;

    logic [1:0] g_kind [MAX_RESULTS];
    logic [7:0] g_char [MAX_RESULTS];
    logic [2:0] g_cnt;

    logic       out_free;
    logic       emit;
    logic       is_last;
    logic       retire;
    logic [7:0] c;

    assign c = r_in.in_byte;

    // Decode of the held byte: result list and next scan state.
    always_comb begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            g_kind[i] = KIND_END_CMDS;
            g_char[i] = CH_NUL;
        end
        g_cnt   = 3'd0;
        n_state = r_state;

        unique case (r_state)
            ST_DONE: begin
                n_state = ST_DONE;
            end
            ST_PLAIN: begin
                if (is_sep(c)) begin
                    g_kind[g_cnt[1:0]] = KIND_END_TOKEN;
                    g_cnt   = g_cnt + 3'd1;
                    n_state = ST_IDLE;
                end else begin
                    g_kind[g_cnt[1:0]] = KIND_CHAR;
                    g_char[g_cnt[1:0]] = c;
                    g_cnt   = g_cnt + 3'd1;
                    n_state = ST_PLAIN;
                end
            end
            ST_QUOTE: begin
                if (is_quote(c)) begin
                    g_kind[g_cnt[1:0]] = KIND_END_TOKEN;
                    g_cnt   = g_cnt + 3'd1;
                    n_state = ST_IDLE;
                end else begin
                    g_kind[g_cnt[1:0]] = KIND_CHAR;
                    g_char[g_cnt[1:0]] = (c == CH_TAB) ? CH_SPACE : c;
                    g_cnt = g_cnt + 3'd1;
                end
            end
            ST_SLASH: begin
                if (c == CH_SLASH) begin
                    n_state = ST_COMMENT;
                end else begin
                    // lone slash: emit it, then the byte continues the token or, if a separator, ends it
                    g_kind[g_cnt[1:0]] = KIND_CHAR;
                    g_char[g_cnt[1:0]] = CH_SLASH;
                    g_cnt = g_cnt + 3'd1;
                    if (is_sep(c)) begin
                        g_kind[g_cnt[1:0]] = KIND_END_TOKEN;
                        g_cnt   = g_cnt + 3'd1;
                        n_state = ST_IDLE;
                    end else begin
                        g_kind[g_cnt[1:0]] = KIND_CHAR;
                        g_char[g_cnt[1:0]] = c;
                        g_cnt   = g_cnt + 3'd1;
                        n_state = ST_PLAIN;
                    end
                end
            end
            ST_COMMENT: begin
                if ((c == CH_LF) || (c == CH_CR)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                // between tokens; stray codes behave the same
                n_state = ST_IDLE;
                if (is_sep(c)) begin
                    n_state = ST_IDLE;
                end else if (c == CH_EOC) begin
                    g_kind[g_cnt[1:0]] = KIND_END_CMDS;
                    g_cnt   = g_cnt + 3'd1;
                    n_state = ST_DONE;
                end else if (r_comments_en && (c == CH_HASH)) begin
                    n_state = ST_COMMENT;
                end else if (r_comments_en && (c == CH_SLASH)) begin
                    n_state = ST_SLASH;
                end else if (is_quote(c)) begin
                    n_state = ST_QUOTE;
                end else begin
                    g_kind[g_cnt[1:0]] = KIND_CHAR;
                    g_char[g_cnt[1:0]] = c;
                    g_cnt   = g_cnt + 3'd1;
                    n_state = ST_PLAIN;
                end
            end
        endcase

        // stream end: flush any open token, then end of commands
        if (r_in.end_of_input && (r_state != ST_DONE) && (n_state != ST_DONE)) begin
            if (n_state == ST_SLASH) begin
                g_kind[g_cnt[1:0]] = KIND_CHAR;
                g_char[g_cnt[1:0]] = CH_SLASH;
                g_cnt = g_cnt + 3'd1;
                g_kind[g_cnt[1:0]] = KIND_END_TOKEN;
                g_cnt = g_cnt + 3'd1;
            end else if ((n_state == ST_PLAIN) || (n_state == ST_QUOTE)) begin
                g_kind[g_cnt[1:0]] = KIND_END_TOKEN;
                g_cnt = g_cnt + 3'd1;
            end
            g_kind[g_cnt[1:0]] = KIND_END_CMDS;
            g_cnt   = g_cnt + 3'd1;
            n_state = ST_DONE;
        end
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign emit       = r_in_valid && (g_cnt != 3'd0) && out_free;
    assign is_last    = ({1'b0, r_idx} == (g_cnt - 3'd1));
    assign retire     = r_in_valid && ((g_cnt == 3'd0) || (emit && is_last));
    assign o_in_stall = r_in_valid && !retire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_comments_en <= 1'b1;
            r_in_valid    <= 1'b0;
            r_idx         <= 2'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_comments_en <= i_cfg_wr_data;
            end
            if (retire) begin
                r_state <= n_state;
                r_idx   <= 2'd0;
            end else if (emit) begin
                r_idx <= r_idx + 2'd1;
            end
            if (!r_in_valid || retire) begin
                r_in_valid <= i_in_valid;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (emit) begin
            r_out.out_char    <= g_char[r_idx];
            r_out.kind        <= g_kind[r_idx];
            r_out.last_in_run <= is_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `CTT_ASSERT_IMPL(a_idx_in_range, r_in_valid && (g_cnt != 3'd0), {1'b0, r_idx} < g_cnt,
        "result index beyond the byte's result count")
    `CTT_ASSERT_IMPL(a_done_silent, r_in_valid && (r_state == ST_DONE), retire && !emit,
        "byte after end of commands produced a result")
    `CTT_ASSERT_NEXT(a_state_only_on_retire, !retire, $stable(r_state),
        "scan state changed without retiring a byte")

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for command_text_tokenizer_unit: random byte streams, a scan-state
// predictor and an in-order result check. Depends on ctt_pkg and the RTL top level only.
module tb;
    import ctt_pkg::*;

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_PLAIN, SCAN_QUOTE, SCAN_SLASH, SCAN_COMMENT, SCAN_DONE
    } scan_e;

    localparam int DRAIN_CYCLES     = 4;
    localparam int HOLD_CYCLES      = 60;
    localparam int HOLD_AFTER_BEATS = 40;
    localparam int MAX_REPORTS      = 10;

    logic      clk;
    logic      rst_n       = 1'b0;
    logic      drv_valid   = 1'b0;
    t_in_item  drv_data    = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      rx_hold     = 1'b0;
    logic      rx_gap_q    = 1'b0;
    logic      cfg_wr_en   = 1'b0;
    logic      cfg_wr_data = 1'b0;
    wire       out_stall   = rx_hold | rx_gap_q;

    t_in_item  text_bytes[$];
    t_out_item exp_tokens[$];
    t_out_item want_tok;
    scan_e     scan        = SCAN_IDLE;
    logic      comments_on = 1'b1;
    logic      in_taken    = 1'b0;
    logic      out_taken   = 1'b0;
    int        n_fail      = 0;
    int        n_in_beats  = 0;
    int        n_token_bytes = 0;
    int        tx_gap_left = 0;
    int        tx_quiet    = 0;
    int        rx_gap_left = 0;
    int        rx_quiet    = 0;

    command_text_tokenizer_unit dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (drv_valid),
        .i_in_data    (drv_data),
        .o_in_stall   (in_stall),
        .o_out_valid  (out_valid),
        .o_out_data   (out_data),
        .i_out_stall  (out_stall),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------- token predictor ----------------

    function automatic logic splits_token(logic [7:0] c);
        return (c == CH_NUL) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB)
            || (c == CH_SPACE) || (c == CH_COMMA);
    endfunction

    function automatic logic quote_char(logic [7:0] c);
        return (c == CH_DQUOTE) || (c == CH_SQUOTE);
    endfunction

    function automatic void expect_token(logic [1:0] kind, logic [7:0] ch);
        t_out_item r;
        r.out_char    = (kind == KIND_CHAR) ? ch : 8'h00;
        r.kind        = kind;
        r.last_in_run = 1'b0;
        exp_tokens.push_back(r);
    endfunction

    function automatic void continue_plain(logic [7:0] c);
        if (splits_token(c)) begin
            expect_token(KIND_END_TOKEN, 8'h00);
            scan = SCAN_IDLE;
        end else begin
            expect_token(KIND_CHAR, c);
            scan = SCAN_PLAIN;
        end
    endfunction

    function automatic void tokenize_byte(t_in_item beat);
        logic [7:0] c;
        int         n0;
        t_out_item  tail;
        c  = beat.in_byte;
        n0 = exp_tokens.size();
        if (scan != SCAN_DONE) begin
            case (scan)
                SCAN_PLAIN: continue_plain(c);
                SCAN_QUOTE: begin
                    if (quote_char(c)) begin
                        expect_token(KIND_END_TOKEN, 8'h00);
                        scan = SCAN_IDLE;
                    end else begin
                        expect_token(KIND_CHAR, (c == CH_TAB) ? CH_SPACE : c);
                    end
                end
                SCAN_SLASH: begin
                    if (c == CH_SLASH) begin
                        scan = SCAN_COMMENT;
                    end else begin
                        expect_token(KIND_CHAR, CH_SLASH);
                        continue_plain(c);
                    end
                end
                SCAN_COMMENT: begin
                    if (c == CH_LF || c == CH_CR) scan = SCAN_IDLE;
                end
                default: begin
                    if (splits_token(c)) begin
                        scan = SCAN_IDLE;
                    end else if (c == CH_EOC) begin
                        expect_token(KIND_END_CMDS, 8'h00);
                        scan = SCAN_DONE;
                    end else if (comments_on && c == CH_HASH) begin
                        scan = SCAN_COMMENT;
                    end else if (comments_on && c == CH_SLASH) begin
                        scan = SCAN_SLASH;
                    end else if (quote_char(c)) begin
                        scan = SCAN_QUOTE;
                    end else begin
                        expect_token(KIND_CHAR, c);
                        scan = SCAN_PLAIN;
                    end
                end
            endcase
            // stream end closes whatever is open, then ends commands
            if (beat.end_of_input && scan != SCAN_DONE) begin
                if (scan == SCAN_SLASH) begin
                    expect_token(KIND_CHAR, CH_SLASH);
                    expect_token(KIND_END_TOKEN, 8'h00);
                end else if (scan == SCAN_PLAIN || scan == SCAN_QUOTE) begin
                    expect_token(KIND_END_TOKEN, 8'h00);
                end
                expect_token(KIND_END_CMDS, 8'h00);
                scan = SCAN_DONE;
            end
            if (exp_tokens.size() > n0) begin
                tail = exp_tokens.pop_back();
                tail.last_in_run = 1'b1;
                exp_tokens.push_back(tail);
            end
        end
    endfunction

    // ---------------- monitor ----------------

    always @(posedge clk) begin
        if (!rst_n) begin
            in_taken    <= 1'b0;
            out_taken   <= 1'b0;
            scan        = SCAN_IDLE;
            comments_on = 1'b1;
        end else begin
            in_taken  <= drv_valid && !in_stall;
            out_taken <= out_valid && !out_stall;
            if (cfg_wr_en) comments_on = cfg_wr_data;
            if (drv_valid && !in_stall) begin
                tokenize_byte(drv_data);
                n_in_beats++;
            end
            if (out_valid && !out_stall) begin
                if (exp_tokens.size() == 0) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $display("%0t: unexpected result char %h kind %0d last %0b",
                                 $realtime, out_data.out_char, out_data.kind,
                                 out_data.last_in_run);
                end else begin
                    want_tok = exp_tokens.pop_front();
                    if (out_data.out_char !== want_tok.out_char
                            || out_data.kind !== want_tok.kind
                            || out_data.last_in_run !== want_tok.last_in_run) begin
                        n_fail++;
                        if (n_fail <= MAX_REPORTS)
                            $display("%0t: got %h/%0d/%0b exp %h/%0d/%0b (char/kind/last)",
                                     $realtime, out_data.out_char, out_data.kind,
                                     out_data.last_in_run, want_tok.out_char, want_tok.kind,
                                     want_tok.last_in_run);
                    end
                end
            end
        end
    end

    // ---------------- driver and receiver ----------------

    // wait length for the next beat; quiet stretches give back-to-back beats
    function automatic int draw_gap(inout int quiet_left);
        if (rx_hold) return 0;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) quiet_left = $urandom_range(5, 20);
        return $urandom_range(0, 9);
    endfunction

    always @(negedge clk) begin
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else if (!drv_valid || in_taken) begin
            if (drv_valid) tx_gap_left = draw_gap(tx_quiet);
            if (tx_gap_left > 0) begin
                tx_gap_left--;
                drv_valid <= 1'b0;
            end else if (text_bytes.size() > 0) begin
                drv_valid <= 1'b1;
                drv_data  <= text_bytes.pop_front();
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            rx_gap_q <= 1'b0;
        end else begin
            if (out_taken) rx_gap_left = draw_gap(rx_quiet);
            if (rx_gap_left > 0) begin
                rx_gap_left--;
                rx_gap_q <= 1'b1;
            end else begin
                rx_gap_q <= 1'b0;
            end
        end
    end

    // long receiver hold-off so both registers fill and the input stalls
    initial begin
        while (n_in_beats < HOLD_AFTER_BEATS) @(posedge clk);
        @(negedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold <= 1'b0;
    end

    // ---------------- stimulus ----------------

    task automatic push_byte(logic [7:0] b, logic eoi = 1'b0);
        t_in_item it;
        it.in_byte      = b;
        it.end_of_input = eoi;
        text_bytes.push_back(it);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_seps();
        repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 5))
                0: push_byte(CH_NUL);
                1: push_byte(CH_LF);
                2: push_byte(CH_CR);
                3: push_byte(CH_TAB);
                4: push_byte(CH_SPACE);
                default: push_byte(CH_COMMA);
            endcase
        end
    endtask

    // 0xFF is never the first byte, only later and before any quote, so it never lands at a token start
    task automatic push_word(bit lead_slash);
        logic [7:0] c;
        int         len;
        int         r;
        bit         quoted;
        quoted = 1'b0;
        if (lead_slash) begin
            push_byte(CH_SLASH);
        end else begin
            do c = 8'($urandom_range(1, 254));
            while (splits_token(c) || quote_char(c) || c == CH_HASH || c == CH_SLASH);
            push_byte(c);
        end
        len = $urandom_range(0, 5);
        repeat (len) begin
            r = $urandom_range(0, 9);
            if (r == 0 && !quoted) begin
                c = CH_EOC;
            end else if (r == 1) begin
                c = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            end else begin
                do c = 8'($urandom_range(1, 254));
                while (splits_token(c));
            end
            quoted |= quote_char(c);
            push_byte(c);
        end
        n_token_bytes += len + 1;
        push_seps();
    endtask

    task automatic push_quoted();
        logic [7:0] c;
        int         len;
        len = $urandom_range(0, 6);
        push_byte($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
        repeat (len) begin
            if ($urandom_range(0, 4) == 0) begin
                c = CH_TAB;
            end else begin
                do c = 8'($urandom_range(0, 254));
                while (quote_char(c));
            end
            push_byte(c);
        end
        push_byte($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
        n_token_bytes += len + 2;
        if ($urandom_range(0, 1)) push_seps();
    endtask

    task automatic push_comment();
        logic [7:0] c;
        if ($urandom_range(0, 1)) begin
            push_byte(CH_HASH);
        end else begin
            push_byte(CH_SLASH);
            push_byte(CH_SLASH);
        end
        repeat ($urandom_range(0, 6)) begin
            do c = 8'($urandom_range(0, 254));
            while (c == CH_LF || c == CH_CR);
            push_byte(c);
        end
        push_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
        if ($urandom_range(0, 1)) push_seps();
    endtask

    task automatic push_random_text(int target);
        int len;
        n_token_bytes = 0;
        while (n_token_bytes < target) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: push_word(1'b0);
                8, 9:                   push_word(1'b1);
                10, 11, 12, 13:         push_quoted();
                14, 15, 16:             push_comment();
                17: begin
                    len = $urandom_range(1, 3);
                    repeat (len) push_byte(8'($urandom_range(0, 254)));
                    n_token_bytes += len;
                end
                default: push_seps();
            endcase
        end
    endtask

    // sender drained, all results back, then a drain wait so silent bytes retire
    task automatic wait_idle();
        while (text_bytes.size() > 0 || drv_valid) @(posedge clk);
        while (exp_tokens.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_comments(logic v);
        wait_idle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        // comments on (reset value): hash comment with 0xFF, whitespace after it
        push_text("# ");
        push_byte(CH_EOC);
        push_text("\n\t");
        push_text("//\n");
        push_text("/a,");                   // lone slash starts a token
        push_text("b'#");                   // quote and hash inside a plain token
        push_byte(CH_EOC);
        push_byte(CH_SPACE);
        push_text("\"\t");                  // quoted: tab, NUL, newline, closed by other quote
        push_byte(CH_NUL);
        push_text("\n'");
        push_text("''");                    // empty quoted token
        push_byte(8'h01);
        push_byte(8'h7F);
        push_byte(8'h80);
        push_byte(8'hFE);
        push_byte(CH_SPACE);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_comments(1'b0);
        push_text("#/a ");                  // hash and slash are plain characters now
        push_random_text(18);

        write_comments(1'b1);
        push_random_text(16);

        write_comments(1'($urandom_range(0, 1)));
        push_byte(CH_LF);
        case ($urandom_range(0, 5))
            0: begin
                push_text("a");
                push_byte("b", 1'b1);
            end
            1: begin
                push_byte(CH_DQUOTE);
                push_byte("x", 1'b1);
            end
            2: push_byte(CH_SLASH, 1'b1);
            3: push_byte(CH_SPACE, 1'b1);
            4: push_byte(CH_EOC);
            default: push_byte(CH_EOC, 1'b1);
        endcase
        // after end of commands these should stay silent
        push_byte("z");
        push_byte(CH_EOC, 1'b1);
        push_byte(CH_DQUOTE);
        wait_idle();

        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/ctt_pkg.sv
rtl/core/command_text_tokenizer_unit.sv
dv/tb.sv
